FILE: design/ksto_pkg.sv
// ----------------------------------------------------------------------------
// ksto_pkg
// Shared types, codes and helpers for the keyed station table.
// ----------------------------------------------------------------------------
package ksto_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned SEEN_W   = 32;
  localparam int unsigned DAY_W    = 18;
  localparam int unsigned FRAMES_W = 32;
  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned SNR_W    = 8;
  localparam int unsigned FREQ_W   = 16;

  localparam logic [DAY_W-1:0]    DAY_UNKNOWN = 18'h3FFFF;
  localparam logic [FRAMES_W-1:0] FRAMES_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_EMPTY    = 3'd0,
    ST_SELF     = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_EVICTED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_WRITE
  } ctrl_state_e;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [SEEN_W-1:0]   last_seen;
    logic [DAY_W-1:0]    day_time;
    logic [FRAMES_W-1:0] frames;
    logic [SCORE_W-1:0]  score;
    logic [SNR_W-1:0]    snr;
    logic [FREQ_W-1:0]   freq;
  } entry_t;

  // ascii a-z folded to A-Z, byte by byte
  function automatic logic [KEY_W-1:0] fold_upper(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    logic [7:0]       b;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      b = k[8*i +: 8];
      if (b >= 8'h61 && b <= 8'h7A) begin
        b = b - 8'h20;
      end
      r[8*i +: 8] = b;
    end
    return r;
  endfunction

endpackage

FILE: design/ksto_table.sv
// ----------------------------------------------------------------------------
// ksto_table
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ksto_table import ksto_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic                             clk_i,
  input  logic                             rd_en_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr_i,
  output entry_t                           rd_data_o,
  input  logic                             wr_en_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr_i,
  input  entry_t                           wr_data_i
);

  entry_t mem_q [TABLE_ENTRIES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/ksto_ctrl.sv
// ----------------------------------------------------------------------------
// ksto_ctrl
// Classifies each event and issues its result. For a key that is neither
// empty nor own, scans for a hit and the oldest entry, then writes back.
// ----------------------------------------------------------------------------
module ksto_ctrl import ksto_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned KEY_BYTES     = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [KEY_W-1:0]                 station_key_i,
  input  logic [SEEN_W-1:0]                now_seconds_i,
  input  logic [16:0]                      day_seconds_i,
  input  logic                             day_time_valid_i,
  input  logic signed [SCORE_W-1:0]        frame_score_i,
  input  logic signed [SNR_W-1:0]          snr_db_i,
  input  logic [FREQ_W-1:0]                audio_freq_tenths_i,
  input  logic [KEY_W-1:0]                 own_key_i,
  output logic                             done_o,
  output logic [2:0]                       status_o,
  output logic [4:0]                       slot_o,
  output logic [FRAMES_W-1:0]              heard_frames_o,
  output logic [5:0]                       entries_used_o,
  output logic [KEY_W-1:0]                 evicted_key_o,
  output logic                             rd_en_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr_o,
  input  entry_t                           rd_data_i,
  output logic                             wr_en_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr_o,
  output entry_t                           wr_data_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
                                          ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

  ctrl_state_e state_q, state_d;

  // control
  logic             done_q;
  logic [CNT_W-1:0] used_q;
  logic [CNT_W-1:0] issue_q;
  logic             rd_vld_q;
  logic             hit_q;

  // request and scan payload
  logic [KEY_W-1:0]    key_q;
  logic [SEEN_W-1:0]   now_q;
  logic [DAY_W-1:0]    day_q;
  logic [SCORE_W-1:0]  score_q;
  logic [SNR_W-1:0]    snr_q;
  logic [FREQ_W-1:0]   freq_q;
  logic [IDX_W-1:0]    rd_idx_q;
  logic [IDX_W-1:0]    hit_idx_q;
  logic [FRAMES_W-1:0] hit_frames_q;
  logic [SEEN_W-1:0]   min_seen_q;
  logic [IDX_W-1:0]    min_idx_q;
  logic [KEY_W-1:0]    min_key_q;

  // result
  status_e             status_q;
  logic [4:0]          slot_q;
  logic [FRAMES_W-1:0] frames_q;
  logic [KEY_W-1:0]    evict_q;

  logic             accept;
  logic [KEY_W-1:0] key_in;
  logic [KEY_W-1:0] own_m;
  logic             is_empty;
  logic             is_self;
  logic             scan_done;
  logic             match;
  logic             room;

  logic [IDX_W-1:0]    slot_sel;
  logic [FRAMES_W-1:0] frames_sel;
  logic [KEY_W-1:0]    evict_sel;
  status_e             st_sel;
  logic [IDX_W+4:0]    slot_ext;
  logic [CNT_W+5:0]    used_ext;

  assign accept    = start && (state_q == CS_IDLE);
  assign key_in    = station_key_i & KEY_MASK;
  assign own_m     = own_key_i & KEY_MASK;
  assign is_empty  = (key_in == '0);
  assign is_self   = (own_m != '0) && (fold_upper(key_in) == fold_upper(own_m));
  assign scan_done = (issue_q == used_q) && !rd_vld_q;
  assign match     = rd_vld_q && !hit_q && (rd_data_i.key == key_q);
  assign room      = (used_q < FULL);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (accept && !is_empty && !is_self) begin
          state_d = CS_SCAN;
        end
      end
      CS_SCAN: begin
        if (scan_done) begin
          state_d = CS_WRITE;
        end
      end
      CS_WRITE: begin
        state_d = CS_IDLE;
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy      = (state_q != CS_IDLE);
    rd_en_o   = (state_q == CS_SCAN) && (issue_q != used_q);
    rd_addr_o = issue_q[IDX_W-1:0];
    wr_en_o   = (state_q == CS_WRITE);
  end

  // write-back decision
  always_comb begin
    priority if (hit_q) begin
      slot_sel   = hit_idx_q;
      frames_sel = (hit_frames_q == FRAMES_MAX) ? FRAMES_MAX : hit_frames_q + 1'b1;
      evict_sel  = '0;
      st_sel     = ST_UPDATED;
    end else if (room) begin
      slot_sel   = used_q[IDX_W-1:0];
      frames_sel = FRAMES_W'(1);
      evict_sel  = '0;
      st_sel     = ST_INSERTED;
    end else begin
      slot_sel   = min_idx_q;
      frames_sel = FRAMES_W'(1);
      evict_sel  = min_key_q;
      st_sel     = ST_EVICTED;
    end
  end

  assign wr_addr_o          = slot_sel;
  assign wr_data_o.key       = key_q;
  assign wr_data_o.last_seen = now_q;
  assign wr_data_o.day_time  = day_q;
  assign wr_data_o.frames    = frames_sel;
  assign wr_data_o.score     = score_q;
  assign wr_data_o.snr       = snr_q;
  assign wr_data_o.freq      = freq_q;

  assign slot_ext = {5'd0, slot_sel};
  assign used_ext = {6'd0, used_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= CS_IDLE;
      done_q   <= 1'b0;
      used_q   <= '0;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= (accept && (is_empty || is_self)) || (state_q == CS_WRITE);
      rd_vld_q <= rd_en_o;
      if (accept) begin
        issue_q <= '0;
        hit_q   <= 1'b0;
      end else begin
        if (rd_en_o) begin
          issue_q <= issue_q + 1'b1;
        end
        if (match) begin
          hit_q <= 1'b1;
        end
      end
      if ((state_q == CS_WRITE) && !hit_q && room) begin
        used_q <= used_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_addr_o;
    if (accept) begin
      key_q    <= key_in;
      now_q    <= now_seconds_i;
      day_q    <= day_time_valid_i ? {1'b0, day_seconds_i} : DAY_UNKNOWN;
      score_q  <= frame_score_i;
      snr_q    <= snr_db_i;
      freq_q   <= audio_freq_tenths_i;
      status_q <= is_empty ? ST_EMPTY : ST_SELF;
      slot_q   <= '0;
      frames_q <= '0;
      evict_q  <= '0;
    end
    if (match) begin
      hit_idx_q    <= rd_idx_q;
      hit_frames_q <= rd_data_i.frames;
    end
    // oldest entry, lowest index on ties
    if (rd_vld_q && ((rd_idx_q == '0) || (rd_data_i.last_seen < min_seen_q))) begin
      min_seen_q <= rd_data_i.last_seen;
      min_idx_q  <= rd_idx_q;
      min_key_q  <= rd_data_i.key;
    end
    if (state_q == CS_WRITE) begin
      status_q <= st_sel;
      slot_q   <= slot_ext[4:0];
      frames_q <= frames_sel;
      evict_q  <= evict_sel;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;
  assign heard_frames_o = frames_q;
  assign entries_used_o = used_ext[5:0];
  assign evicted_key_o  = evict_q;

endmodule

FILE: design/keyed_station_table_oldest_evict_top.sv
// ----------------------------------------------------------------------------
// keyed_station_table_oldest_evict_top
// Station table keyed by packed callsign with oldest-entry eviction.
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low. An empty key or the
// own key gives its result on done_o in the next cycle. Any other key is
// looked up by a scan that reads one table entry per cycle from the entry
// memory, over the occupied entries only, and its result appears on done_o
// after the write-back. busy falls in the cycle done_o is high, so the next
// event may be taken then. Results are held on the output ports for one
// cycle only and must be captured when done_o is high; the receiver cannot
// stall them.
// The own key register accepts a write in any cycle and should be changed
// only while busy is low and no result is pending.
module keyed_station_table_oldest_evict_top import ksto_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned KEY_BYTES     = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [KEY_W-1:0]          cfg_data_i,
  input  logic                      start,
  output logic                      busy,
  input  logic [KEY_W-1:0]          station_key_i,
  input  logic [SEEN_W-1:0]         now_seconds_i,
  input  logic [16:0]               day_seconds_i,
  input  logic                      day_time_valid_i,
  input  logic signed [SCORE_W-1:0] frame_score_i,
  input  logic signed [SNR_W-1:0]   snr_db_i,
  input  logic [FREQ_W-1:0]         audio_freq_tenths_i,
  output logic                      done_o,
  output logic [2:0]                status_o,
  output logic [4:0]                slot_o,
  output logic [FRAMES_W-1:0]       heard_frames_o,
  output logic [5:0]                entries_used_o,
  output logic [KEY_W-1:0]          evicted_key_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  logic [KEY_W-1:0] own_key_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_key_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      own_key_q <= cfg_data_i;
    end
  end

  ksto_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .KEY_BYTES    (KEY_BYTES)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .station_key_i      (station_key_i),
    .now_seconds_i      (now_seconds_i),
    .day_seconds_i      (day_seconds_i),
    .day_time_valid_i   (day_time_valid_i),
    .frame_score_i      (frame_score_i),
    .snr_db_i           (snr_db_i),
    .audio_freq_tenths_i(audio_freq_tenths_i),
    .own_key_i          (own_key_q),
    .done_o             (done_o),
    .status_o           (status_o),
    .slot_o             (slot_o),
    .heard_frames_o     (heard_frames_o),
    .entries_used_o     (entries_used_o),
    .evicted_key_o      (evicted_key_o),
    .rd_en_o            (rd_en),
    .rd_addr_o          (rd_addr),
    .rd_data_i          (rd_data),
    .wr_en_o            (wr_en),
    .wr_addr_o          (wr_addr),
    .wr_data_o          (wr_data)
  );

  ksto_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

endmodule

FILE: design/ksto_checker.sv
// ----------------------------------------------------------------------------
// ksto_checker
// Port-level checks on the station table, bound to the top level.
// ----------------------------------------------------------------------------
module ksto_checker import ksto_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic [KEY_W-1:0]    station_key_i,
  input logic                done_o,
  input logic [2:0]          status_o,
  input logic [FRAMES_W-1:0] heard_frames_o,
  input logic [KEY_W-1:0]    evicted_key_o
);

  // empty key answers in the next cycle
  a_empty_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (station_key_i == '0) |=> done_o && (status_o == ST_EMPTY))
    else $error("empty key not answered in next cycle");

  // busy only rises after a taken transaction
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start) && !$past(busy))
    else $error("busy rose without a transaction");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= ST_EVICTED))
    else $error("status code out of range");

  // a touched entry always has a nonzero count
  a_frames_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_UPDATED || status_o == ST_INSERTED ||
               status_o == ST_EVICTED) |-> (heard_frames_o != '0))
    else $error("touched entry reports zero frames");

  a_evict_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_EVICTED) |-> (evicted_key_o == '0))
    else $error("evicted key set without eviction");

endmodule

bind keyed_station_table_oldest_evict_top ksto_checker u_ksto_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .station_key_i (station_key_i),
  .done_o        (done_o),
  .status_o      (status_o),
  .heard_frames_o(heard_frames_o),
  .evicted_key_o (evicted_key_o)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed station table with oldest-entry eviction.
// Frame events go in through the start/busy handshake with random idle gaps.
// The own key register is reloaded between phases. A scoreboard keeps its own
// copy of the station table and compares every done_o result field by field.
// ----------------------------------------------------------------------------
module tb;
  import ksto_pkg::*;

  localparam int unsigned TABLE_SIZE  = 32;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct {
    logic [KEY_W-1:0]          key;
    logic [SEEN_W-1:0]         seen_at;
    logic [16:0]               day_sec;
    logic                      day_ok;
    logic signed [SCORE_W-1:0] score;
    logic signed [SNR_W-1:0]   snr;
    logic [FREQ_W-1:0]         freq;
  } frame_event_t;

  typedef struct {
    status_e             status;
    logic [4:0]          slot;
    logic [FRAMES_W-1:0] frames;
    logic [5:0]          used;
    logic [KEY_W-1:0]    evicted;
  } station_result_t;

  class station_board;
    entry_t          stations [TABLE_SIZE];
    int unsigned     occupied;
    logic [KEY_W-1:0] own_key;
    station_result_t expected_q [$];
    int unsigned     mismatches;

    function new();
      occupied   = 0;
      own_key    = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_own_key(logic [KEY_W-1:0] value);
      own_key = value;
    endfunction

    // lower-case letters lose bit 5
    function logic [KEY_W-1:0] upcase(logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      r = k;
      for (int i = 0; i < 8; i++) begin
        if (k[8*i +: 8] >= 8'h61 && k[8*i +: 8] <= 8'h7A) begin
          r[8*i + 5] = 1'b0;
        end
      end
      return r;
    endfunction

    function void note_frame(frame_event_t ev);
      station_result_t r;
      int unsigned     idx;
      bit              hit;
      r.status  = ST_EMPTY;
      r.slot    = '0;
      r.frames  = '0;
      r.evicted = '0;
      if (ev.key == '0) begin
        r.status = ST_EMPTY;
      end else if (own_key != '0 && upcase(ev.key) == upcase(own_key)) begin
        r.status = ST_SELF;
      end else begin
        hit = 1'b0;
        idx = 0;
        for (int i = 0; i < occupied; i++) begin
          if (!hit && stations[i].key == ev.key) begin
            hit = 1'b1;
            idx = i;
          end
        end
        if (hit) begin
          r.status = ST_UPDATED;
        end else begin
          if (occupied < TABLE_SIZE) begin
            idx = occupied;
            occupied++;
            r.status = ST_INSERTED;
          end else begin
            idx = 0;
            for (int i = 1; i < TABLE_SIZE; i++) begin
              if (stations[i].last_seen < stations[idx].last_seen) begin
                idx = i;
              end
            end
            r.evicted = stations[idx].key;
            r.status  = ST_EVICTED;
          end
          stations[idx].key    = ev.key;
          stations[idx].frames = '0;
        end
        stations[idx].last_seen = ev.seen_at;
        stations[idx].day_time  = ev.day_ok ? {1'b0, ev.day_sec} : DAY_UNKNOWN;
        stations[idx].score     = ev.score;
        stations[idx].snr       = ev.snr;
        stations[idx].freq      = ev.freq;
        if (stations[idx].frames != FRAMES_MAX) begin
          stations[idx].frames = stations[idx].frames + 1'b1;
        end
        r.slot   = 5'(idx);
        r.frames = stations[idx].frames;
      end
      r.used = 6'(occupied);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [2:0] status, logic [4:0] slot,
                               logic [FRAMES_W-1:0] frames, logic [5:0] used,
                               logic [KEY_W-1:0] evicted);
      station_result_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: status %0d slot %0d frames %0d used %0d evicted %h",
                   status, slot, frames, used, evicted);
        end
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (status !== want.status || slot !== want.slot || frames !== want.frames ||
          used !== want.used || evicted !== want.evicted) begin
        if (mismatches < 10) begin
          $display("mismatch: expected status %0d slot %0d frames %0d used %0d evicted %h",
                   want.status, want.slot, want.frames, want.used, want.evicted);
          $display("          actual   status %0d slot %0d frames %0d used %0d evicted %h",
                   status, slot, frames, used, evicted);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [KEY_W-1:0]          cfg_data_i = '0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [KEY_W-1:0]          station_key_i = '0;
  logic [SEEN_W-1:0]         now_seconds_i = '0;
  logic [16:0]               day_seconds_i = '0;
  logic                      day_time_valid_i = 1'b0;
  logic signed [SCORE_W-1:0] frame_score_i = '0;
  logic signed [SNR_W-1:0]   snr_db_i = '0;
  logic [FREQ_W-1:0]         audio_freq_tenths_i = '0;
  logic                      done_o;
  logic [2:0]                status_o;
  logic [4:0]                slot_o;
  logic [FRAMES_W-1:0]       heard_frames_o;
  logic [5:0]                entries_used_o;
  logic [KEY_W-1:0]          evicted_key_o;

  station_board     sb;
  int unsigned      cycles = 0;
  logic [KEY_W-1:0] own_setting = '0;
  logic [KEY_W-1:0] call_pool [48];
  logic [SEEN_W-1:0] clock_stamp = 32'd1000;
  logic [SEEN_W-1:0] tie_stamp = '0;

  keyed_station_table_oldest_evict_top #(
    .TABLE_ENTRIES(TABLE_SIZE),
    .KEY_BYTES    (8)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .start              (start),
    .busy               (busy),
    .station_key_i      (station_key_i),
    .now_seconds_i      (now_seconds_i),
    .day_seconds_i      (day_seconds_i),
    .day_time_valid_i   (day_time_valid_i),
    .frame_score_i      (frame_score_i),
    .snr_db_i           (snr_db_i),
    .audio_freq_tenths_i(audio_freq_tenths_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .slot_o             (slot_o),
    .heard_frames_o     (heard_frames_o),
    .entries_used_o     (entries_used_o),
    .evicted_key_o      (evicted_key_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin : watch
    frame_event_t f;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_own_key(cfg_data_i);
      end
      if (done_o) begin
        sb.check_result(status_o, slot_o, heard_frames_o, entries_used_o, evicted_key_o);
      end
      if (start && !busy) begin
        f.key     = station_key_i;
        f.seen_at = now_seconds_i;
        f.day_sec = day_seconds_i;
        f.day_ok  = day_time_valid_i;
        f.score   = frame_score_i;
        f.snr     = snr_db_i;
        f.freq    = audio_freq_tenths_i;
        sb.note_frame(f);
      end
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [KEY_W-1:0] make_call();
    logic [KEY_W-1:0] k;
    int unsigned      len;
    k   = '0;
    len = $urandom_range(3, 8);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0, 1:    k[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 25));
        2:       k[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 25));
        default: k[8*i +: 8] = 8'h30 + 8'($urandom_range(0, 9));
      endcase
    end
    return k;
  endfunction

  // flips the case of a random subset of letters
  function automatic logic [KEY_W-1:0] recase(logic [KEY_W-1:0] k);
    logic [7:0] c;
    for (int i = 0; i < 8; i++) begin
      c = k[8*i +: 8];
      if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
          $urandom_range(0, 1) == 1) begin
        k[8*i + 5] = ~k[8*i + 5];
      end
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int unsigned span);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 10 && own_setting != '0) return recase(own_setting);
    if (roll < 18) return recase(call_pool[$urandom_range(0, span - 1)]);
    if (roll < 25) return {$urandom(), $urandom()};
    return call_pool[$urandom_range(0, span - 1)];
  endfunction

  function automatic frame_event_t frame_of(logic [KEY_W-1:0] key, logic [SEEN_W-1:0] seen,
                                            logic [16:0] day_sec, logic day_ok,
                                            logic [SCORE_W-1:0] score, logic [SNR_W-1:0] snr,
                                            logic [FREQ_W-1:0] freq);
    frame_event_t f;
    f.key     = key;
    f.seen_at = seen;
    f.day_sec = day_sec;
    f.day_ok  = day_ok;
    f.score   = score;
    f.snr     = snr;
    f.freq    = freq;
    return f;
  endfunction

  function automatic frame_event_t random_frame(logic [KEY_W-1:0] key);
    logic [SEEN_W-1:0] seen;
    logic [16:0]       day_sec;
    int unsigned       roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      seen = $urandom();
    end else if (roll == 1) begin
      seen = tie_stamp;
    end else begin
      clock_stamp = clock_stamp + 32'($urandom_range(0, 30));
      seen = clock_stamp;
    end
    roll = $urandom_range(0, 9);
    if (roll < 8) begin
      day_sec = 17'($urandom_range(0, 86399));
    end else if (roll == 8) begin
      day_sec = 17'($urandom_range(86400, 131071));
    end else begin
      day_sec = $urandom_range(0, 1) ? 17'd86399 : 17'd0;
    end
    return frame_of(key, seen, day_sec, $urandom_range(0, 6) != 0,
                    16'($urandom()), 8'($urandom()), 16'($urandom()));
  endfunction

  task automatic send_frame(input frame_event_t f, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start               <= 1'b1;
    station_key_i       <= f.key;
    now_seconds_i       <= f.seen_at;
    day_seconds_i       <= f.day_sec;
    day_time_valid_i    <= f.day_ok;
    frame_score_i       <= f.score;
    snr_db_i            <= f.snr;
    audio_freq_tenths_i <= f.freq;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0 || busy);
  endtask

  task automatic load_own_key(input logic [KEY_W-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    own_setting = value;
  endtask

  initial begin : main
    logic [KEY_W-1:0] own;
    int unsigned      span;
    int unsigned      gap;
    bit               steady;
    sb = new();
    for (int i = 0; i < 48; i++) begin
      call_pool[i] = make_call();
    end
    // a few calls with zero bytes inside
    call_pool[5][15:8]  = 8'h00;
    call_pool[11][23:8] = 16'h0000;
    call_pool[17]       = 64'h5A00_0031_0000_4B57;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // own key "Ab1cD"
    load_own_key(64'h0000_0044_6331_6241);
    send_frame(frame_of('0, 32'hFFFF_FFFF, 17'd86399, 1'b1, 16'h7FFF, 8'h7F, 16'hFFFF), 0);
    send_frame(frame_of(64'h0000_0044_6331_6241, 32'd5, 17'd0, 1'b1, 16'h0, 8'h0, 16'h0), 2);
    send_frame(frame_of(64'h0000_0044_4331_4241, 32'd6, 17'd1, 1'b0, 16'h1, 8'h1, 16'h1), 0);
    send_frame(frame_of(64'h0000_0064_6331_6261, 32'd7, 17'd2, 1'b1, 16'h2, 8'h2, 16'h2), 1);
    send_frame(frame_of('1, 32'd0, 17'd86399, 1'b1, 16'h8000, 8'h80, 16'h0), 0);
    send_frame(frame_of(64'h5A00_0031_0000_4B57, 32'hFFFF_FFFF, 17'h1FFFF, 1'b1,
                        16'h7FFF, 8'h7F, 16'hFFFF), 5);
    send_frame(frame_of(64'h5A00_0031_0000_4B57, 32'd100, 17'd500, 1'b0,
                        16'h1234, 8'hF0, 16'h0F0F), 0);
    send_frame(frame_of(64'h0000_0000_0043_4241, 32'd20, 17'd3600, 1'b1,
                        16'hFFFF, 8'hFF, 16'hAAAA), 3);
    send_frame(frame_of(64'h0000_0000_0063_6261, 32'd20, 17'd3601, 1'b1,
                        16'h5555, 8'h55, 16'h5555), 0);
    send_frame(frame_of(64'h0000_0000_0043_4241, 32'd21, 17'd3602, 1'b1,
                        16'h0001, 8'h01, 16'h0001), 12);
    send_frame(frame_of(64'h8000_0000_0000_0001, 32'd22, 17'h10000, 1'b1,
                        16'h8000, 8'h80, 16'h8000), 0);
    // zero disables dropping of the own key
    load_own_key('0);
    send_frame(frame_of(64'h0000_0044_6331_6241, 32'd30, 17'd10, 1'b1, 16'h0, 8'h0, 16'h0), 0);
    send_frame(frame_of('0, 32'd31, 17'd11, 1'b1, 16'h0, 8'h0, 16'h0), 0);
    send_frame(frame_of(64'h0000_0044_6331_6241, 32'd32, 17'd12, 1'b0, 16'h0, 8'h0, 16'h0), 4);

    steady = 1'b0;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       begin own = '0;                     span = 20; end
        1:       begin own = recase(call_pool[3]);   span = 48; end
        2:       begin own = '1;                     span = 40; end
        3:       begin own = make_call();            span = 36; end
        default: begin own = call_pool[7];           span = 24; end
      endcase
      load_own_key(own);
      tie_stamp = 32'(p * 3);
      for (int n = 0; n < 76; n++) begin
        if ($urandom_range(0, 19) == 0) begin
          steady = ~steady;
        end
        gap = steady ? 0 : idle_gap();
        if (p == 2 && n == 38) begin
          drain_results();
        end
        send_frame(random_frame(pick_key(span)), gap);
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: keyed_station_table_oldest_evict_top.f
design/ksto_pkg.sv
design/ksto_table.sv
design/ksto_ctrl.sv
design/keyed_station_table_oldest_evict_top.sv
design/ksto_checker.sv
sim/tb.sv
